// ===== sv/dsd_pkg.sv =====
// Shared types, constants and helpers for the dielectric scatter direction unit.
`timescale 1ns / 1ps
package dsd_pkg;

	localparam int FRAC_BITS_DEF = 13;
	localparam logic [15:0] IDX_RESET = 16'd6144;
	localparam int SQRT_ITER = 31;

	// Per-ray pipeline record; each stage fills in its own fields.
	typedef struct packed {
		logic [2:0][15:0] d;
		logic [2:0][15:0] n;
		logic             front;
		logic [15:0]      chance;
		logic [28:0]      eta;
		logic [30:0]      r0;
		logic [2:0][31:0] pr;
		logic [33:0]      dot;
		logic [2:0][49:0] rp;
		logic [31:0]      c;
		logic [60:0]      cc;
		logic [31:0]      x;
		logic             xbig;
		logic [29:0]      x2;
		logic [29:0]      x4;
		logic [30:0]      p;
		logic [30:0]      reflm;
		logic [45:0]      etac;
		logic [2:0][15:0] rdir;
		logic [61:0]      v;
		logic [30:0]      sinv;
		logic [59:0]      esp;
		logic             tir;
		logic [30:0]      es;
		logic [61:0]      es2;
		logic             reflect;
		logic [30:0]      sk;
		logic [47:0]      coef;
		logic [2:0][45:0] t1;
		logic [2:0][63:0] t2;
		logic [2:0][15:0] o;
	} dsd_item_t;

	// Material terms derived from the refraction index register.
	// r0 reaches exactly one when the ratio is zero.
	typedef struct packed {
		logic        busy;
		logic [28:0] eta_back;
		logic [28:0] eta_front;
		logic [30:0] r0_back;
		logic [30:0] r0_front;
	} dsd_eta_t;

	function automatic logic [15:0] sat16(input logic signed [63:0] v);
		logic [15:0] r;
		if (v > 64'sd32767) begin
			r = 16'h7fff;
		end else if (v < -64'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/dielectric_scatter_direction_unit.sv =====
// Top level: dielectric scatter direction pipeline (refract or Schlick reflect).
// Pipeline: 13 datapath stages plus two 31-stage square-root pipelines from an accepted
// input word to its output word. Throughput: one word per cycle unless the output stalls.
// Reset and every index register write start a background pass (three serial divides)
// computing the reciprocal ratio and r0 terms; s_tready is low during it. Reset clears
// all valid bits; the index resets to 1.5.
`timescale 1ns / 1ps
module dielectric_scatter_direction_unit #(
	parameter int FRAC_BITS = dsd_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// input words
	input  logic         s_tvalid,
	output logic         s_tready,
	// [15:0] dir_x, [31:16] dir_y, [47:32] dir_z, [63:48] normal_x,
	// [79:64] normal_y, [95:80] normal_z, [111:96] chance
	input  logic [111:0] s_tdata,
	// [0] outside hit flag (reciprocal ratio)
	input  logic         s_tuser,
	// output words
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] out_x, [31:16] out_y, [47:32] out_z
	output logic [47:0]  m_tdata,
	// [0] reflected
	output logic         m_tuser,
	// index register write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	localparam int F2  = 2 * FRAC_BITS;
	// dot product carries 2*FRAC_BITS fraction bits; cos wants 30
	localparam int SHR = (F2 >= 30) ? F2 - 30 : 0;
	localparam int SHL = (F2 >= 30) ? 0 : 30 - F2;
	localparam int NSQ = dsd_pkg::SQRT_ITER;
	localparam int TAG_W = $bits(dsd_pkg::dsd_item_t);

	localparam logic signed [47:0] ONE30_48 = 48'sd1073741824;
	localparam logic signed [31:0] ONE30_32 = 32'sd1073741824;
	localparam logic [61:0] ONE60 = 62'(1) << 60;
	localparam logic [59:0] TIR_LIM = 60'(1) << 46;
	localparam logic [30:0] ONE30_U = 31'(1) << 30;

	dsd_pkg::dsd_eta_t eta;

	dsd_eta_unit u_eta (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.eta       (eta)
	);

	// Global advance: the whole pipe moves unless the output word is stalled.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en && !eta.busy;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;
	dsd_pkg::dsd_item_t p_s1, p_s2, p_s3, p_s4, p_s5, p_s6;
	dsd_pkg::dsd_item_t p_s7, p_s8, p_s9, p_s10, p_s11, p_s12, p_s13;
	dsd_pkg::dsd_item_t nx1, nx2, nx3, nx4, nx5, nx6;
	dsd_pkg::dsd_item_t nx7, nx8, nx9, nx10, nx11, nx12, nx13;

	logic               sqa_valid, sqb_valid;
	logic [NSQ-1:0]     sqa_root, sqb_root;
	logic [TAG_W-1:0]   sqa_tag, sqb_tag;

	// S1: unpack the word, pick ratio and r0 by face
	always_comb begin
		nx1        = '0;
		nx1.d[0]   = s_tdata[15:0];
		nx1.d[1]   = s_tdata[31:16];
		nx1.d[2]   = s_tdata[47:32];
		nx1.n[0]   = s_tdata[63:48];
		nx1.n[1]   = s_tdata[79:64];
		nx1.n[2]   = s_tdata[95:80];
		nx1.chance = s_tdata[111:96];
		nx1.front  = s_tuser;
		nx1.eta    = s_tuser ? eta.eta_front : eta.eta_back;
		nx1.r0     = s_tuser ? eta.r0_front : eta.r0_back;
	end

	// S2: per-lane products of d and n
	always_comb begin
		logic signed [31:0] m;
		nx2 = p_s1;
		for (int i = 0; i < 3; i++) begin
			m = $signed(p_s1.d[i]) * $signed(p_s1.n[i]);
			nx2.pr[i] = m;
		end
	end

	// S3: dot product
	always_comb begin
		logic signed [33:0] a0, a1, a2;
		nx3 = p_s2;
		a0 = $signed(p_s2.pr[0]);
		a1 = $signed(p_s2.pr[1]);
		a2 = $signed(p_s2.pr[2]);
		nx3.dot = a0 + a1 + a2;
	end

	// S4: cos = -dot rescaled to 30 fraction bits, clamped to [-1,1];
	// dot*n for the mirror direction
	always_comb begin
		logic signed [47:0] nd;
		logic signed [47:0] cw;
		logic signed [49:0] m;
		nx4 = p_s3;
		nd = $signed(p_s3.dot);
		nd = -nd;
		cw = (nd >>> SHR) <<< SHL;
		if (cw > ONE30_48) begin
			cw = ONE30_48;
		end else if (cw < -ONE30_48) begin
			cw = -ONE30_48;
		end
		nx4.c = cw[31:0];
		for (int i = 0; i < 3; i++) begin
			m = $signed(p_s3.dot) * $signed(p_s3.n[i]);
			nx4.rp[i] = m;
		end
	end

	// S5: cos^2, 1-cos, eta*cos, mirror direction d - 2(d.n)n
	always_comb begin
		logic signed [63:0] csq;
		logic signed [61:0] ec;
		logic signed [51:0] tw;
		logic signed [52:0] dl;
		logic signed [52:0] rd;
		nx5 = p_s4;
		csq = $signed(p_s4.c) * $signed(p_s4.c);
		nx5.cc = csq[60:0];
		nx5.x = 32'(ONE30_32 - $signed(p_s4.c));
		ec = $signed({1'b0, p_s4.eta}) * $signed(p_s4.c);
		nx5.etac = ec[61:16];
		for (int i = 0; i < 3; i++) begin
			tw = {p_s4.rp[i][49], p_s4.rp[i], 1'b0};
			tw = tw >>> F2;
			dl = $signed(p_s4.d[i]);
			rd = dl - tw;
			nx5.rdir[i] = dsd_pkg::sat16(64'(rd));
		end
	end

	// S6: sin^2 argument for the first root; (1-cos)^2
	always_comb begin
		logic [59:0] sq;
		nx6 = p_s5;
		nx6.v = ONE60 - {1'b0, p_s5.cc};
		nx6.xbig = p_s5.x[31] | p_s5.x[30];
		sq = p_s5.x[29:0] * p_s5.x[29:0];
		nx6.x2 = sq[59:30];
	end

	dsd_isqrt_pipe #(.N(NSQ), .TAG_W(TAG_W)) u_sqrt_sin (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.in_v      (p_s6.v),
		.in_tag    (p_s6),
		.out_valid (sqa_valid),
		.out_root  (sqa_root),
		.out_tag   (sqa_tag)
	);

	// S7: sin, eta*sin, (1-cos)^4
	always_comb begin
		logic [59:0] sq;
		nx7 = dsd_pkg::dsd_item_t'(sqa_tag);
		nx7.sinv = sqa_root;
		nx7.esp = nx7.eta * sqa_root;
		sq = nx7.x2 * nx7.x2;
		nx7.x4 = sq[59:30];
	end

	// S8: total internal reflection test, (1-cos)^5 saturating at one
	always_comb begin
		logic [59:0] m;
		nx8 = p_s7;
		nx8.tir = p_s7.esp > TIR_LIM;
		nx8.es = p_s7.esp[46:16];
		m = p_s7.x4 * p_s7.x[29:0];
		nx8.p = p_s7.xbig ? ONE30_U : {1'b0, m[59:30]};
	end

	// S9: (eta sin)^2, (1-r0)*(1-cos)^5
	always_comb begin
		logic [61:0] m;
		nx9 = p_s8;
		nx9.es2 = p_s8.es * p_s8.es;
		m = (ONE30_U - p_s8.r0) * p_s8.p;
		nx9.reflm = m[60:30];
	end

	// S10: reflectance vs chance; argument of the second root
	always_comb begin
		logic [31:0] refl;
		nx10 = p_s9;
		nx10.v = ONE60 - p_s9.es2;
		refl = {1'b0, p_s9.r0} + {1'b0, p_s9.reflm};
		nx10.reflect = p_s9.tir || (refl > {2'd0, p_s9.chance, 14'd0});
	end

	dsd_isqrt_pipe #(.N(NSQ), .TAG_W(TAG_W)) u_sqrt_k (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s10),
		.in_v      (p_s10.v),
		.in_tag    (p_s10),
		.out_valid (sqb_valid),
		.out_root  (sqb_root),
		.out_tag   (sqb_tag)
	);

	// S11: refraction coefficient sqrt(1 - eta^2 sin^2) - eta cos, eta*d
	always_comb begin
		logic signed [47:0] skx;
		logic signed [47:0] ecx;
		logic signed [45:0] m;
		nx11 = dsd_pkg::dsd_item_t'(sqb_tag);
		nx11.sk = sqb_root;
		skx = $signed({17'd0, sqb_root});
		ecx = $signed(nx11.etac);
		nx11.coef = skx - ecx;
		for (int i = 0; i < 3; i++) begin
			m = $signed({1'b0, nx11.eta}) * $signed(nx11.d[i]);
			nx11.t1[i] = m;
		end
	end

	// S12: coef*n
	always_comb begin
		logic signed [63:0] m;
		nx12 = p_s11;
		for (int i = 0; i < 3; i++) begin
			m = $signed(p_s11.coef) * $signed(p_s11.n[i]);
			nx12.t2[i] = m;
		end
	end

	// S13: refracted direction, saturate, choose
	always_comb begin
		logic signed [63:0] a;
		logic signed [63:0] df;
		nx13 = p_s12;
		for (int i = 0; i < 3; i++) begin
			a = $signed(p_s12.t1[i]);
			a = a <<< 14;
			df = (a - $signed(p_s12.t2[i])) >>> 30;
			nx13.o[i] = p_s12.reflect ? p_s12.rdir[i] : dsd_pkg::sat16(df);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_tvalid && !eta.busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= sqa_valid;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= sqb_valid;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= nx1;
			p_s2  <= nx2;
			p_s3  <= nx3;
			p_s4  <= nx4;
			p_s5  <= nx5;
			p_s6  <= nx6;
			p_s7  <= nx7;
			p_s8  <= nx8;
			p_s9  <= nx9;
			p_s10 <= nx10;
			p_s11 <= nx11;
			p_s12 <= nx12;
			p_s13 <= nx13;
		end
	end

	assign m_tvalid = vld_s13;
	assign m_tdata  = {p_s13.o[2], p_s13.o[1], p_s13.o[0]};
	assign m_tuser  = p_s13.reflect;

	// cos stays within [-1,1] after the clamp
	a_cos_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> ($signed(p_s5.c) <= ONE30_32 && $signed(p_s5.c) >= -ONE30_32))
		else $error("cos outside clamp range");

	// a refracted ray has sqrt(1 - eta^2 sin^2) no larger than one
	a_sk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s12 && !p_s12.reflect) |-> (p_s12.sk <= ONE30_U))
		else $error("refraction root out of range");

	// total internal reflection always selects the mirror direction
	a_tir_reflects: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s11 && p_s11.tir) |-> p_s11.reflect)
		else $error("total internal reflection not reflected");

	// no word enters while material terms are being recomputed
	a_no_entry_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(en && $past(eta.busy) && eta.busy) |=> !vld_s1)
		else $error("word accepted during ratio update");

endmodule

// ===== sv/dsd_divider.sv =====
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dsd_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [58:0] num,
	input  logic [28:0] den,
	output logic        done,
	output logic [30:0] quo
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [28:0] rem_q;
	logic [28:0] den_q;
	logic [30:0] sh_q;
	logic [29:0] trial;
	logic        ge;

	// numerator bits shift out of the top while quotient bits enter below
	assign trial = {rem_q, sh_q[30]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 5'd1;
			done_q <= (cnt_q == 5'd30);
			busy_q <= (cnt_q != 5'd30);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num[58:31]};
			sh_q  <= num[30:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? 29'(trial - {1'b0, den_q}) : trial[28:0];
			sh_q  <= {sh_q[29:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

endmodule

// ===== sv/dsd_eta_unit.sv =====
// Index register and background computation of refraction ratios and Schlick r0.
`timescale 1ns / 1ps
module dsd_eta_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	output dsd_pkg::dsd_eta_t  eta
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SE   = 4'd1;
	localparam logic [3:0] ST_DE   = 4'd2;
	localparam logic [3:0] ST_SB   = 4'd3;
	localparam logic [3:0] ST_DB   = 4'd4;
	localparam logic [3:0] ST_MB   = 4'd5;
	localparam logic [3:0] ST_SF   = 4'd6;
	localparam logic [3:0] ST_DF   = 4'd7;
	localparam logic [3:0] ST_MF   = 4'd8;

	localparam logic [28:0] ONE16 = 29'd65536;

	logic [3:0]  state_q;
	logic [15:0] idx_q;
	logic [28:0] eta_front_q;
	logic [30:0] q_q;
	logic [30:0] r0_back_q;
	logic [30:0] r0_front_q;

	logic [28:0] eta_back;
	logic [28:0] eta_sel;
	logic [28:0] ediff;
	logic        div_start;
	logic [58:0] div_num;
	logic [28:0] div_den;
	logic        div_done;
	logic [30:0] div_quo;
	logic [61:0] qsq;

	assign eta_back = {9'd0, idx_q, 4'd0};
	assign eta_sel  = (state_q == ST_SF) ? eta_front_q : eta_back;
	assign ediff    = (eta_sel >= ONE16) ? 29'(eta_sel - ONE16) : 29'(ONE16 - eta_sel);
	assign qsq      = q_q * q_q;

	always_comb begin
		div_start = 1'b0;
		div_num   = {ediff, 30'd0};
		div_den   = 29'(eta_sel + ONE16);
		case (state_q)
			ST_SE: begin
				div_start = 1'b1;
				div_num   = 59'(1) << 28;
				div_den   = {13'd0, (idx_q == 16'd0) ? 16'd1 : idx_q};
			end
			ST_SB, ST_SF: begin
				div_start = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	dsd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SE;
			idx_q   <= dsd_pkg::IDX_RESET;
		end else if (cfg_valid) begin
			idx_q   <= cfg_data;
			state_q <= ST_SE;
		end else begin
			case (state_q)
				ST_SE: state_q <= ST_DE;
				ST_DE: if (div_done) begin
					state_q <= ST_SB;
				end
				ST_SB: state_q <= ST_DB;
				ST_DB: if (div_done) begin
					state_q <= ST_MB;
				end
				ST_MB: state_q <= ST_SF;
				ST_SF: state_q <= ST_DF;
				ST_DF: if (div_done) begin
					state_q <= ST_MF;
				end
				ST_MF: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DE && div_done) begin
			eta_front_q <= div_quo[28:0];
		end
		if ((state_q == ST_DB || state_q == ST_DF) && div_done) begin
			q_q <= div_quo;
		end
		if (state_q == ST_MB) begin
			r0_back_q <= qsq[60:30];
		end
		if (state_q == ST_MF) begin
			r0_front_q <= qsq[60:30];
		end
	end

	assign cfg_ready     = 1'b1;
	assign eta.busy      = (state_q != ST_IDLE);
	assign eta.eta_back  = eta_back;
	assign eta.eta_front = eta_front_q;
	assign eta.r0_back   = r0_back_q;
	assign eta.r0_front  = r0_front_q;

endmodule

// ===== sv/dsd_isqrt_pipe.sv =====
// Pipelined integer square root, one root bit per stage, with a carried tag.
`timescale 1ns / 1ps
module dsd_isqrt_pipe #(
	parameter int N     = dsd_pkg::SQRT_ITER,
	parameter int TAG_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [2*N-1:0]     in_v,
	input  logic [TAG_W-1:0]   in_tag,
	output logic               out_valid,
	output logic [N-1:0]       out_root,
	output logic [TAG_W-1:0]   out_tag
);

	logic               vld_s  [1:N];
	logic [2*N-1:0]     rem_s  [1:N];
	logic [2*N-1:0]     root_s [1:N];
	logic [TAG_W-1:0]   tag_s  [1:N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [2*N-1:0] BIT = (2*N)'(1) << (2 * (N - 1 - k));
		logic               src_vld;
		logic [2*N-1:0]     src_rem;
		logic [2*N-1:0]     src_root;
		logic [TAG_W-1:0]   src_tag;
		logic [2*N-1:0]     trial;

		if (k == 0) begin : g_first
			assign src_vld  = in_valid;
			assign src_rem  = in_v;
			assign src_root = '0;
			assign src_tag  = in_tag;
		end else begin : g_next
			assign src_vld  = vld_s[k];
			assign src_rem  = rem_s[k];
			assign src_root = root_s[k];
			assign src_tag  = tag_s[k];
		end

		assign trial = src_root + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k+1] <= src_tag;
				if (src_rem >= trial) begin
					rem_s[k+1]  <= src_rem - trial;
					root_s[k+1] <= (src_root >> 1) + BIT;
				end else begin
					rem_s[k+1]  <= src_rem;
					root_s[k+1] <= src_root >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_root  = root_s[N][N-1:0];
	assign out_tag   = tag_s[N];

endmodule
